[sv/edm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// edm_pkg
// Shared constants, widths and codes for the distance matrix row engine.
// ----------------------------------------------------------------------------
package edm_pkg;

    localparam int MAX_CITIES = 64;
    localparam int COORD_BITS = 20;
    localparam int FRAC_BITS  = 8;

    localparam int IDX_W   = $clog2(MAX_CITIES);
    localparam int CNT_W   = $clog2(MAX_CITIES + 1);
    localparam int ENTRY_W = 2 * COORD_BITS;
    localparam int SQ_W    = 2 * COORD_BITS;
    localparam int SUM_W   = SQ_W + 1;
    // radicand rounded up to an even number of bits, root takes one bit per pair
    localparam int RAD_W   = ((SUM_W + 2 * FRAC_BITS + 1) / 2) * 2;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 1;
    localparam int ITER_W  = $clog2(ROOT_W);

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_ROW    = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage
`default_nettype wire

[sv/edm_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// edm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module edm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[sv/euclidean_distance_matrix_rows.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// euclidean_distance_matrix_rows
// City list with row-by-row Euclidean distance output, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   A command is transferred when start is high and busy is low. Clear and
//   append finish in that cycle (busy stays low). Append on a full list, and
//   a row command whose row_index is not below the city count, give a single
//   status result in the next cycle.
//   A row command gives one result per stored city, in column order, with
//   last set on the final one. Each column passes through a RAM read, the
//   difference, two squarings on the shared multiplier, one add, 29 steps
//   of the bit-pair square root unit and one output step. While a row runs
//   busy stays high and no command is taken; the last result comes in the
//   same cycle as busy falls.
//   Each result sits on the result ports for one cycle with valid high; the
//   receiver must take it then, it cannot stall the block.
//   Reset empties the list and returns the sequencer to idle; the store
//   contents are not cleared, only entries below the count are read.
// ----------------------------------------------------------------------------
module euclidean_distance_matrix_rows
    import edm_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   command,
    input  wire logic signed [COORD_BITS-1:0] x_coord,
    input  wire logic signed [COORD_BITS-1:0] y_coord,
    input  wire logic [IDX_W-1:0]             row_index,
    output logic                              valid,
    output logic [ROOT_W-1:0]                 distance,
    output logic [IDX_W-1:0]                  column,
    output logic                              last,
    output logic [1:0]                        status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROW,
        S_ISSUE,
        S_FETCH,
        S_SQX,
        S_SQY,
        S_SUM,
        S_ROOT,
        S_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [IDX_W-1:0]       col_reg, col_next;
    logic [COORD_BITS-1:0]  row_x_reg, row_x_next;
    logic [COORD_BITS-1:0]  row_y_reg, row_y_next;
    logic [COORD_BITS-1:0]  dx_reg, dx_next;
    logic [COORD_BITS-1:0]  dy_reg, dy_next;
    logic [SQ_W-1:0]        sqx_reg, sqx_next;
    logic [SQ_W-1:0]        sqy_reg, sqy_next;
    logic [RAD_W-1:0]       rad_reg, rad_next;
    logic [ROOT_W-1:0]      root_reg, root_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [ITER_W-1:0]      iter_reg, iter_next;
    logic                   valid_reg, valid_next;
    logic [ROOT_W-1:0]      distance_reg, distance_next;
    logic [IDX_W-1:0]       column_reg, column_next;
    logic                   last_reg, last_next;
    logic [1:0]             status_reg, status_next;

    logic                   accept;
    logic                   full;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]     ram_rdata;
    logic [COORD_BITS-1:0]  rd_x, rd_y;
    logic signed [COORD_BITS:0] diff_x, diff_y;
    logic [COORD_BITS-1:0]  mul_op;
    logic [SQ_W-1:0]        mul_prod;
    logic [SUM_W-1:0]       sq_sum;
    logic [REM_W+1:0]       rem_sh;
    logic [REM_W+1:0]       trial;
    logic                   col_last;

    assign accept = start && (state_reg == S_IDLE);
    assign full   = (count_reg == CNT_W'(MAX_CITIES));
    assign ram_we = accept && (command == CMD_APPEND) && !full;
    assign ram_raddr = (state_reg == S_IDLE) ? row_index : col_reg;

    edm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_CITIES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata ({x_coord, y_coord}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_x = ram_rdata[ENTRY_W-1:COORD_BITS];
    assign rd_y = ram_rdata[COORD_BITS-1:0];

    assign diff_x = $signed({row_x_reg[COORD_BITS-1], row_x_reg})
                  - $signed({rd_x[COORD_BITS-1], rd_x});
    assign diff_y = $signed({row_y_reg[COORD_BITS-1], row_y_reg})
                  - $signed({rd_y[COORD_BITS-1], rd_y});

    // shared squaring unit
    assign mul_op   = (state_reg == S_SQX) ? dx_reg : dy_reg;
    assign mul_prod = mul_op * mul_op;

    assign sq_sum = SUM_W'(sqx_reg) + SUM_W'(sqy_reg);

    // one root bit per step: bring down the next bit pair, try 4*root+1
    assign rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial  = (REM_W + 2)'({root_reg, 2'b01});

    assign col_last = ((CNT_W'(col_reg) + CNT_W'(1)) == count_reg);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        col_next      = col_reg;
        row_x_next    = row_x_reg;
        row_y_next    = row_y_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        sqx_next      = sqx_reg;
        sqy_next      = sqy_reg;
        rad_next      = rad_reg;
        root_next     = root_reg;
        rem_next      = rem_reg;
        iter_next     = iter_reg;
        valid_next    = 1'b0;
        distance_next = distance_reg;
        column_next   = column_reg;
        last_next     = last_reg;
        status_next   = status_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_APPEND:
                        begin
                            if (full)
                            begin
                                valid_next    = 1'b1;
                                distance_next = '0;
                                column_next   = '0;
                                last_next     = 1'b1;
                                status_next   = ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_ROW:
                        begin
                            if (CNT_W'(row_index) >= count_reg)
                            begin
                                valid_next    = 1'b1;
                                distance_next = '0;
                                column_next   = row_index;
                                last_next     = 1'b1;
                                status_next   = ST_RANGE;
                            end
                            else
                            begin
                                col_next   = '0;
                                state_next = S_ROW;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ROW:
            begin
                row_x_next = rd_x;
                row_y_next = rd_y;
                state_next = S_FETCH;
            end
            S_ISSUE:
            begin
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                dx_next    = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x)
                                                : diff_x[COORD_BITS-1:0];
                dy_next    = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y)
                                                : diff_y[COORD_BITS-1:0];
                state_next = S_SQX;
            end
            S_SQX:
            begin
                sqx_next   = mul_prod;
                state_next = S_SQY;
            end
            S_SQY:
            begin
                sqy_next   = mul_prod;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                rad_next   = RAD_W'(sq_sum) << (2 * FRAC_BITS);
                root_next  = '0;
                rem_next   = '0;
                iter_next  = ITER_W'(ROOT_W - 1);
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                rad_next = rad_reg << 2;
                if (rem_sh >= trial)
                begin
                    rem_next  = REM_W'(rem_sh - trial);
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh[REM_W-1:0];
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                if (iter_reg == '0)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    iter_next = iter_reg - ITER_W'(1);
                end
            end
            S_EMIT:
            begin
                valid_next    = 1'b1;
                distance_next = root_reg;
                column_next   = col_reg;
                last_next     = col_last;
                status_next   = ST_OK;
                if (col_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    col_next   = col_reg + IDX_W'(1);
                    state_next = S_ISSUE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            col_reg      <= '0;
            iter_reg     <= '0;
            valid_reg    <= 1'b0;
            distance_reg <= '0;
            column_reg   <= '0;
            last_reg     <= 1'b0;
            status_reg   <= ST_OK;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            col_reg      <= col_next;
            iter_reg     <= iter_next;
            valid_reg    <= valid_next;
            distance_reg <= distance_next;
            column_reg   <= column_next;
            last_reg     <= last_next;
            status_reg   <= status_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        row_x_reg <= row_x_next;
        row_y_reg <= row_y_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        sqx_reg   <= sqx_next;
        sqy_reg   <= sqy_next;
        rad_reg   <= rad_next;
        root_reg  <= root_next;
        rem_reg   <= rem_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign valid    = valid_reg;
    assign distance = distance_reg;
    assign column   = column_reg;
    assign last     = last_reg;
    assign status   = status_reg;

endmodule
`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the distance matrix row engine against its own predictor: city
// list, fixed point distances, out of range rows, the full list status and
// the unused command, under random start gaps and result bursts.
// ----------------------------------------------------------------------------
module tb;
    import edm_pkg::*;

    // the fourth command code has no meaning and must be ignored
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 290;

    typedef struct {
        logic [ROOT_W-1:0] distance;
        logic [IDX_W-1:0]  column;
        logic              last;
        status_t           status;
    } dist_result_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [1:0]                   command;
    logic signed [COORD_BITS-1:0] x_coord;
    logic signed [COORD_BITS-1:0] y_coord;
    logic [IDX_W-1:0]             row_index;
    logic                         valid;
    logic [ROOT_W-1:0]            distance;
    logic [IDX_W-1:0]             column;
    logic                         last;
    logic [1:0]                   status;

    // predictor state
    logic signed [COORD_BITS-1:0] city_x [MAX_CITIES];
    logic signed [COORD_BITS-1:0] city_y [MAX_CITIES];
    int                           city_total;
    dist_result_t                 rows_due [$];

    int mismatches;
    int items_sent;
    bit no_gaps;

    euclidean_distance_matrix_rows dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .x_coord   (x_coord),
        .y_coord   (y_coord),
        .row_index (row_index),
        .valid     (valid),
        .distance  (distance),
        .column    (column),
        .last      (last),
        .status    (status)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // floor(sqrt(rad)), two radicand bits per step
    function automatic logic [ROOT_W-1:0] int_sqrt(input logic [63:0] rad);
        logic [63:0] root;
        logic [63:0] rem;
        logic [63:0] trial;
        root = '0;
        rem  = '0;
        for (int i = 31; i >= 0; i--)
        begin
            rem   = (rem << 2) | ((rad >> (2 * i)) & 64'd3);
            trial = (root << 2) | 64'd1;
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end
            else
            begin
                root = root << 1;
            end
        end
        return root[ROOT_W-1:0];
    endfunction

    function automatic logic [ROOT_W-1:0] city_distance(input int a, input int b);
        longint dx;
        longint dy;
        logic [63:0] sum_sq;
        dx = longint'(city_x[a]) - longint'(city_x[b]);
        dy = longint'(city_y[a]) - longint'(city_y[b]);
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        sum_sq = 64'(dx * dx) + 64'(dy * dy);
        return int_sqrt(sum_sq << (2 * FRAC_BITS));
    endfunction

    task automatic predict_command(input logic [1:0] cmd,
                                   input logic signed [COORD_BITS-1:0] x,
                                   input logic signed [COORD_BITS-1:0] y,
                                   input logic [IDX_W-1:0] row);
        dist_result_t r;
        case (cmd)
            CMD_CLEAR:
                city_total = 0;
            CMD_APPEND:
                if (city_total >= MAX_CITIES)
                begin
                    r = '{distance: '0, column: '0, last: 1'b1, status: ST_FULL};
                    rows_due.insert(rows_due.size(), r);
                end
                else
                begin
                    city_x[city_total] = x;
                    city_y[city_total] = y;
                    city_total++;
                end
            CMD_ROW:
                if (int'(row) >= city_total)
                begin
                    r = '{distance: '0, column: row, last: 1'b1, status: ST_RANGE};
                    rows_due.insert(rows_due.size(), r);
                end
                else
                begin
                    for (int j = 0; j < city_total; j++)
                    begin
                        r.distance = (j == int'(row)) ? '0 : city_distance(int'(row), j);
                        r.column   = IDX_W'(j);
                        r.last     = (j + 1 == city_total);
                        r.status   = ST_OK;
                        rows_due.insert(rows_due.size(), r);
                    end
                end
            default:
                ;
        endcase
    endtask

    // one command transfer; called at a rising edge
    task automatic send_cmd(input logic [1:0] cmd,
                            input logic signed [COORD_BITS-1:0] x,
                            input logic signed [COORD_BITS-1:0] y,
                            input logic [IDX_W-1:0] row);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        command   <= cmd;
        x_coord   <= x;
        y_coord   <= y;
        row_index <= row;
        do
            @(posedge clk);
        while (busy);
        predict_command(cmd, x, y, row);
        if (cmd != CMD_UNUSED)
            items_sent++;
    endtask

    task automatic send_append(input logic signed [COORD_BITS-1:0] x,
                               input logic signed [COORD_BITS-1:0] y);
        send_cmd(CMD_APPEND, x, y, IDX_W'($urandom));
    endtask

    task automatic send_row(input logic [IDX_W-1:0] row);
        send_cmd(CMD_ROW, COORD_BITS'($urandom), COORD_BITS'($urandom), row);
    endtask

    task automatic send_clear();
        send_cmd(CMD_CLEAR, COORD_BITS'($urandom), COORD_BITS'($urandom),
                 IDX_W'($urandom));
    endtask

    // hold off until every outstanding result has been seen
    task automatic drain_results();
        start <= 1'b0;
        while (rows_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [COORD_BITS-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0, 1:    return COORD_BITS'(int'($urandom_range(0, 16)) - 8);
            2:       return $urandom_range(0, 1) ? {1'b1, {(COORD_BITS-1){1'b0}}}
                                                 : {1'b0, {(COORD_BITS-1){1'b1}}};
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    task automatic test_empty_list();
        send_row(IDX_W'(0));
        send_row({IDX_W{1'b1}});
        send_cmd(CMD_UNUSED, '1, '1, '1);
        send_row(IDX_W'(1));
    endtask

    task automatic test_extremes_and_diagonal();
        send_append({1'b1, {(COORD_BITS-1){1'b0}}}, {1'b1, {(COORD_BITS-1){1'b0}}});
        send_append({1'b0, {(COORD_BITS-1){1'b1}}}, {1'b0, {(COORD_BITS-1){1'b1}}});
        send_append('0, '0);
        send_append({1'b1, {(COORD_BITS-1){1'b0}}}, {1'b0, {(COORD_BITS-1){1'b1}}});
        send_append(COORD_BITS'(3), COORD_BITS'(4));
        send_row(IDX_W'(0));
        send_row(IDX_W'(1));
        send_row(IDX_W'(4));
        send_row(IDX_W'(5));
        drain_results();
        // duplicate point: zero distance off the diagonal
        send_append(COORD_BITS'(3), COORD_BITS'(4));
        send_row(IDX_W'(5));
        send_clear();
        send_row(IDX_W'(0));
        send_append(COORD_BITS'(1), '0);
        send_append('0, COORD_BITS'(1));
        send_cmd(CMD_UNUSED, '0, '0, '0);
        send_row(IDX_W'(1));
        send_clear();
    endtask

    task automatic test_store_full();
        send_append({1'b1, {(COORD_BITS-1){1'b0}}}, {1'b0, {(COORD_BITS-1){1'b1}}});
        repeat (MAX_CITIES - 2)
            send_append(rand_coord(), rand_coord());
        send_append({1'b0, {(COORD_BITS-1){1'b1}}}, {1'b1, {(COORD_BITS-1){1'b0}}});
        send_append(rand_coord(), rand_coord());
        send_append(rand_coord(), rand_coord());
        send_row(IDX_W'(MAX_CITIES - 1));
        send_row(IDX_W'(0));
        send_clear();
    endtask

    task automatic test_random_traffic();
        int n_cities;
        int n_rows;
        while (items_sent < ITEM_TARGET)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) != 0)
                send_clear();
            n_cities = ($urandom_range(0, 9) == 0) ? $urandom_range(9, MAX_CITIES + 2)
                                                   : $urandom_range(1, 6);
            repeat (n_cities)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_cmd(CMD_UNUSED, COORD_BITS'($urandom), COORD_BITS'($urandom),
                             IDX_W'($urandom));
                send_append(rand_coord(), rand_coord());
            end
            n_rows = $urandom_range(1, 4);
            repeat (n_rows)
            begin
                if (city_total == 0 || $urandom_range(0, 5) == 0)
                    send_row(IDX_W'($urandom_range(0, MAX_CITIES - 1)));
                else
                    send_row(IDX_W'($urandom_range(0, city_total - 1)));
            end
            if ($urandom_range(0, 7) == 0)
                drain_results();
        end
        no_gaps = 1'b0;
    endtask

    // result checker: the block cannot be stalled, so every strobe is a transfer
    always @(posedge clk)
    begin
        dist_result_t want;
        if (rst_n && valid)
        begin
            if (rows_due.size() == 0)
            begin
                $error("unexpected result: column %0d status %0d", column, status);
                mismatches++;
            end
            else
            begin
                want = rows_due.pop_front();
                if (distance !== want.distance)
                begin
                    $error("distance: expected %0d, got %0d", want.distance, distance);
                    mismatches++;
                end
                if (column !== want.column)
                begin
                    $error("column: expected %0d, got %0d", want.column, column);
                    mismatches++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, last);
                    mismatches++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        command    = CMD_CLEAR;
        x_coord    = '0;
        y_coord    = '0;
        row_index  = '0;
        city_total = 0;
        mismatches = 0;
        items_sent = 0;
        no_gaps    = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_extremes_and_diagonal();
        test_store_full();
        test_random_traffic();

        drain_results();
        repeat (80) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
sv/edm_pkg.sv
sv/edm_ram.sv
sv/euclidean_distance_matrix_rows.sv
bench/tb.sv
